### design/bfs_visited_filter_banked_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the visited filter block.
// Both macros expect i_clk in the scope where they are used; BVF_ASSERT_RUN also expects i_rst_n.
// ---------------------------------------------------------------------------
`ifndef BFS_VISITED_FILTER_BANKED_UNIT_ASSERT_SVH
`define BFS_VISITED_FILTER_BANKED_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define BVF_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define BVF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BVF_ASSERT_RUN(lbl, prop, msg)
`define BVF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/bvf_pkg.sv
// ---------------------------------------------------------------------------
// bvf_pkg
// Shared types, opcodes and constants of the visited filter block.
// ---------------------------------------------------------------------------
`default_nettype none

package bvf_pkg;

    // Fixed field widths.
    localparam int ID_W      = 16;
    localparam int LANE_W    = 4;
    localparam int CNT_W     = 13;
    localparam int OP_W      = 2;
    localparam int ROW_SHIFT = 4;
    localparam int XW        = ID_W - ROW_SHIFT;   // width of id >> 4
    localparam int MAX_LANES = 16;

    // Parameter defaults.
    localparam int LANES_DEF    = 16;
    localparam int VERTICES_DEF = 65536;

    localparam logic [ID_W-1:0] ID_EMPTY = 16'hFFFF;

    // Command opcodes.
    localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_LEVEL  = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [63:0]     ids_lanes_0_to_3;
        logic [63:0]     ids_lanes_4_to_7;
        logic [63:0]     ids_lanes_8_to_11;
        logic [63:0]     ids_lanes_12_to_15;
    } t_cmd;

    // Result transaction.
    typedef struct packed {
        logic [ID_W-1:0]   vertex_id;
        logic [LANE_W-1:0] lane;
        logic [CNT_W-1:0]  lane_count;
        logic              last;
    } t_result;

    // Side band that travels with one lane through the row pipeline.
    typedef struct packed {
        logic              act;   // slot holds a lane
        logic              fin;   // final lane of the batch
        logic              vld;   // id is not an empty slot
        logic [LANE_W-1:0] lane;
        logic [ID_W-1:0]   id;
    } t_tag;

    // Control from the sequencer to the result stage.
    typedef struct packed {
        logic hit;       // lane found a new vertex
        logic tail;      // batch done, release the held result
        logic clr_cnt;   // zero all lane counters
    } t_emit_ctl;

endpackage

`default_nettype wire

### design/bvf_ram.sv
// ---------------------------------------------------------------------------
// bvf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bvf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/bvf_row_mod.sv
// ---------------------------------------------------------------------------
// bvf_row_mod
// Three-stage pipeline that reduces id >> 4 modulo the bank depth.
// ---------------------------------------------------------------------------
`default_nettype none

module bvf_row_mod #(
    parameter int BANK_ROWS = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bvf_pkg::t_tag                i_tag,
    input  wire logic [bvf_pkg::XW-1:0]       i_x,
    output bvf_pkg::t_tag                     o_tag,
    output logic      [$clog2(BANK_ROWS)-1:0] o_row
);

    localparam int XW     = bvf_pkg::XW;
    localparam int ROW_AW = $clog2(BANK_ROWS);
    localparam int MW     = ((XW > ROW_AW) ? XW : ROW_AW) + 1;
    // Reciprocal scaled by 2^XW; the quotient estimate is low by at most one.
    localparam int RECIP  = (1 << XW) / BANK_ROWS;
    localparam int RW     = (RECIP > 0) ? $clog2(RECIP + 1) : 1;

    bvf_pkg::t_tag   r_tag1, r_tag2, r_tag3;
    logic [XW-1:0]   r_x1, r_x2;
    logic [RW-1:0]   r_q1;
    logic [MW-1:0]   r_p2;
    logic [ROW_AW-1:0] r_row3;

    logic [XW+RW-1:0] prod1;
    logic [MW-1:0]    diff3;
    logic [MW-1:0]    corr3;

    // Quotient estimate, then back multiply, then remainder with one correction.
    assign prod1 = (XW+RW)'(i_x) * (XW+RW)'(RECIP);
    assign diff3 = MW'(r_x2) - r_p2;
    assign corr3 = (diff3 >= MW'(BANK_ROWS)) ? (diff3 - MW'(BANK_ROWS)) : diff3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_x1   <= i_x;
        r_q1   <= prod1[XW+RW-1:XW];
        r_x2   <= r_x1;
        r_p2   <= MW'(r_q1) * MW'(BANK_ROWS);
        r_row3 <= corr3[ROW_AW-1:0];
    end

    assign o_tag = r_tag3;
    assign o_row = r_row3;

endmodule

`default_nettype wire

### design/bvf_emit.sv
// ---------------------------------------------------------------------------
// bvf_emit
// Lane counters and result staging; holds one result back to mark the last.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bfs_visited_filter_banked_unit_assert.svh"

module bvf_emit #(
    parameter int LANES = bvf_pkg::LANES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bvf_pkg::t_emit_ctl          i_ctl,
    input  wire logic [bvf_pkg::LANE_W-1:0]  i_lane,
    input  wire logic [bvf_pkg::ID_W-1:0]    i_id,
    output logic                             o_strobe,
    output bvf_pkg::t_result                 o_result
);

    localparam int LANE_AW = $clog2(LANES);
    localparam int CNT_W   = bvf_pkg::CNT_W;

    logic [CNT_W-1:0] r_cnt [LANES];
    logic [CNT_W-1:0] n_cnt [LANES];
    bvf_pkg::t_result r_pend, n_pend;
    logic             r_pend_vld, n_pend_vld;
    bvf_pkg::t_result r_out, n_out;
    logic             r_out_vld, n_out_vld;

    logic [CNT_W-1:0] cnt_inc;

    assign cnt_inc = r_cnt[i_lane[LANE_AW-1:0]] + CNT_W'(1);

    // A new hit pushes the held result out; the batch end releases it as last.
    always_comb begin
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = 1'b0;
        if (i_ctl.clr_cnt) begin
            for (int i = 0; i < LANES; i++) begin
                n_cnt[i] = '0;
            end
        end else if (i_ctl.hit) begin
            n_cnt[i_lane[LANE_AW-1:0]] = cnt_inc;
            if (r_pend_vld) begin
                n_out     = r_pend;
                n_out_vld = 1'b1;
            end
            n_pend.vertex_id  = i_id;
            n_pend.lane       = i_lane;
            n_pend.lane_count = cnt_inc;
            n_pend.last       = 1'b0;
            n_pend_vld        = 1'b1;
        end else if (i_ctl.tail && r_pend_vld) begin
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_out_vld  = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_cnt[i] <= '0;
            end
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    `BVF_ASSERT_RUN(a_last_drains, (o_strobe && o_result.last) |-> !r_pend_vld, "last result left a held result")
    `BVF_ASSERT_RUN(a_count_nonzero, o_strobe |-> (o_result.lane_count != '0), "result with zero lane count")
    `BVF_ASSERT_RUN(a_hit_tail_excl, !(i_ctl.hit && i_ctl.tail), "hit during batch tail")

endmodule

`default_nettype wire

### design/bfs_visited_filter_banked_unit.sv
// ---------------------------------------------------------------------------
// bfs_visited_filter_banked_unit
// Banked visited-set filter for one breadth-first-search expansion step.
// ---------------------------------------------------------------------------
// Usage:
//   A command transaction is taken on a rising edge with start high and busy
//   low. Op 0 filters a batch of up to 16 vertex ids, one per lane; lane k
//   looks its id up in visited bank k at row (id >> 4) mod bank depth. Each
//   new id is marked and reported on o_result with a one-cycle o_strobe, in
//   ascending lane order, with last set on the final report of the batch.
//   A batch with nothing new reports nothing.
//   A filter batch keeps busy high while its lanes enter the row pipeline,
//   one per cycle, and pass four stages (three of row reduction, one of bank
//   read), and through a tail state that releases the held last result. A
//   result leaves once the next new vertex of the batch or the batch end
//   releases it; the last one comes in the first cycle with busy low again.
//   Ops 2 and 3 leave busy low. Reset and op 1 run a clearing pass over all
//   banks in parallel, one row a cycle, with busy high; reset and ops 1 and 2
//   zero the lane counters. The receiver cannot stall: each result is on the
//   ports for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bfs_visited_filter_banked_unit_assert.svh"

module bfs_visited_filter_banked_unit #(
    parameter int LANES    = bvf_pkg::LANES_DEF,
    parameter int VERTICES = bvf_pkg::VERTICES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire bvf_pkg::t_cmd     i_cmd,
    output logic                   busy,
    output logic                   o_strobe,
    output bvf_pkg::t_result       o_result
);

    localparam int BANK_ROWS = VERTICES / LANES;
    localparam int ROW_AW    = $clog2(BANK_ROWS);
    localparam int LANE_AW   = $clog2(LANES);
    localparam int LANE_W    = bvf_pkg::LANE_W;
    localparam int ID_W      = bvf_pkg::ID_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_WAIT  = 5'b01000,
        S_TAIL  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [LANE_W-1:0]     r_issue, n_issue;
    logic [ROW_AW-1:0]     r_clr_row, n_clr_row;
    logic [bvf_pkg::MAX_LANES-1:0][ID_W-1:0] r_ids, n_ids;

    bvf_pkg::t_tag         issue_tag;
    logic [ID_W-1:0]       issue_id;
    bvf_pkg::t_tag         row_tag;
    logic [ROW_AW-1:0]     row_idx;
    bvf_pkg::t_tag         r_s4_tag;
    logic [ROW_AW-1:0]     r_s4_row;
    logic [LANES-1:0]      bank_rd;
    logic [LANES-1:0]      bank_we;
    logic                  clearing;
    logic                  s4_hit;
    logic                  accept;
    bvf_pkg::t_emit_ctl    emit_ctl;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign clearing = (r_state == S_CLEAR);

    // Command decode and batch sequencing.
    always_comb begin
        n_state   = r_state;
        n_issue   = r_issue;
        n_clr_row = r_clr_row;
        n_ids     = r_ids;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_row = r_clr_row + ROW_AW'(1);
                if (r_clr_row == ROW_AW'(BANK_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.op)
                        bvf_pkg::OP_FILTER: begin
                            n_state = S_RUN;
                            n_issue = '0;
                            n_ids   = {i_cmd.ids_lanes_12_to_15, i_cmd.ids_lanes_8_to_11,
                                       i_cmd.ids_lanes_4_to_7, i_cmd.ids_lanes_0_to_3};
                        end
                        bvf_pkg::OP_CLEAR: begin
                            n_state   = S_CLEAR;
                            n_clr_row = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_issue = r_issue + LANE_W'(1);
                if (r_issue == LANE_W'(LANES - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (r_s4_tag.act && r_s4_tag.fin) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_issue   <= '0;
            r_clr_row <= '0;
            r_s4_tag  <= '0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_clr_row <= n_clr_row;
            r_s4_tag  <= row_tag;
        end
    end

    // Batch and row payload.
    always_ff @(posedge i_clk) begin
        r_ids    <= n_ids;
        r_s4_row <= row_idx;
    end

    // One lane a cycle enters the row pipeline.
    assign issue_id       = r_ids[r_issue];
    assign issue_tag.act  = (r_state == S_RUN);
    assign issue_tag.fin  = (r_issue == LANE_W'(LANES - 1));
    assign issue_tag.vld  = (issue_id != bvf_pkg::ID_EMPTY);
    assign issue_tag.lane = r_issue;
    assign issue_tag.id   = issue_id;

    bvf_row_mod #(
        .BANK_ROWS (BANK_ROWS)
    ) u_row_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (issue_tag),
        .i_x     (issue_id[ID_W-1:bvf_pkg::ROW_SHIFT]),
        .o_tag   (row_tag),
        .o_row   (row_idx)
    );

    // Visited banks: read at the reduced row, mark in the next cycle.
    // Each lane owns its bank, so a batch never reads a row it is writing.
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        assign bank_we[b] = clearing ||
                            (r_s4_tag.act && r_s4_tag.vld && (r_s4_tag.lane == LANE_W'(b)));

        bvf_ram #(
            .WIDTH (1),
            .DEPTH (BANK_ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (clearing ? r_clr_row : r_s4_row),
            .i_wdata (!clearing),
            .i_raddr (row_idx),
            .o_rdata (bank_rd[b])
        );
    end

    assign s4_hit = r_s4_tag.act && r_s4_tag.vld && !bank_rd[r_s4_tag.lane[LANE_AW-1:0]];

    assign emit_ctl.hit     = s4_hit;
    assign emit_ctl.tail    = (r_state == S_TAIL);
    assign emit_ctl.clr_cnt = accept &&
                              ((i_cmd.op == bvf_pkg::OP_CLEAR) || (i_cmd.op == bvf_pkg::OP_LEVEL));

    bvf_emit #(
        .LANES (LANES)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (emit_ctl),
        .i_lane   (r_s4_tag.lane),
        .i_id     (r_s4_tag.id),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `BVF_ASSERT_RUN(a_idle_quiet, (r_state == S_IDLE) |-> !r_s4_tag.act, "lane in flight while idle")
    `BVF_ASSERT_RUN(a_filter_runs, (accept && (i_cmd.op == bvf_pkg::OP_FILTER)) |=> (r_state == S_RUN), "filter batch did not start")
    `BVF_ASSERT_RUN(a_clear_silent, clearing |-> !o_strobe, "result during clearing pass")

endmodule

`default_nettype wire
